/* rtl/riff_wave_header_parser_macros.svh */
// assertion macros for the riff wave header parser checker
// clocked on clk; RWHP_ASSERT is disabled while rst_n is low
`ifndef RIFF_WAVE_HEADER_PARSER_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_MACROS_SVH

// property checked only out of reset
`define RWHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold across reset
`define RWHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rwhp_pkg.sv */
// ----------------------------------------------------------------------------
// rwhp_pkg
// types and constants shared by the riff wave header parser and its checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwhp_pkg;

  // chunk and form tags, first byte in the high lane
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned RIFF_HDR_BYTES  = 12;
  localparam int unsigned CHUNK_HDR_BYTES = 8;
  localparam int unsigned FMT_BASE_BYTES  = 16;
  localparam logic [15:0] FMT_PCM         = 16'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_bytes;
    logic [15:0] sample_width;
    logic [31:0] extra_offset;
    logic [31:0] extra_length;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] riff_length;
  } out_t;

endpackage

/* rtl/riff_wave_header_parser.sv */
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// output: registered, shown in the cycle after the last byte is taken
// throughput: one byte per cycle, back to back; a last byte waits only while
//   the previous result is still held in the output register
// reset: rst_n synchronous active low, clears parse state and the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module riff_wave_header_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rwhp_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rwhp_pkg::out_t out_data
);

  typedef enum logic [1:0] {
    PH_RIFF,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [32:0] pos_r, pos_nxt;            // byte position, saturating
  logic [32:0] decl_r, decl_nxt;          // declared riff size, plus eight once known
  logic [31:0] room_r, room_nxt;          // bytes left after the current chunk payload
  logic [31:0] shift_r, shift_nxt;        // tag shift register
  logic [23:0] len_lo_r, len_lo_nxt;      // low bytes of chunk length
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;    // byte index in chunk header
  logic [31:0] body_left_r, body_left_nxt;// body bytes left minus one
  logic [4:0]  body_idx_r, body_idx_nxt;  // fmt field index, stops at sixteen
  logic        pad_r, pad_nxt;
  logic        fmt_body_r, fmt_body_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        data_seen_r, data_seen_nxt;
  logic        failed_r, failed_nxt;

  // captured fields
  logic [15:0] format_r, format_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] xstart_r, xstart_nxt;
  logic [31:0] xlen_r, xlen_nxt;
  logic [31:0] dstart_r, dstart_nxt;
  logic [31:0] dlen_r, dlen_nxt;

  // output register
  logic           out_valid_r;
  rwhp_pkg::out_t out_data_r, out_data_nxt;

  // helpers
  logic        in_xfer;
  logic [7:0]  b;
  logic [31:0] shifted;
  logic [32:0] pos_inc;
  logic [32:0] decl_sum;
  logic [31:0] len_full;
  logic [32:0] diff;
  logic [31:0] room_need;
  logic        res_ok;

  // a last byte needs a free output slot; other bytes never do
  assign in_ready = !out_valid_r || out_ready || !in_data.last;
  assign in_xfer  = in_valid && in_ready;

  assign b         = in_data.data_byte;
  assign shifted   = {shift_r[23:0], b};
  assign pos_inc   = (&pos_r) ? pos_r : pos_r + 33'd1;
  assign decl_sum  = decl_r + 33'(rwhp_pkg::CHUNK_HDR_BYTES);
  assign len_full  = {b, len_lo_r};
  // negative means the chunk runs past the declared end
  assign diff      = {1'b0, room_r} - {1'b0, len_full};
  assign room_need = 32'(rwhp_pkg::CHUNK_HDR_BYTES) + {31'd0, pad_r};

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    decl_nxt      = decl_r;
    room_nxt      = room_r;
    shift_nxt     = shift_r;
    len_lo_nxt    = len_lo_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    body_left_nxt = body_left_r;
    body_idx_nxt  = body_idx_r;
    pad_nxt       = pad_r;
    fmt_body_nxt  = fmt_body_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    failed_nxt    = failed_r;
    format_nxt    = format_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    brate_nxt     = brate_r;
    align_nxt     = align_r;
    bits_nxt      = bits_r;
    xstart_nxt    = xstart_r;
    xlen_nxt      = xlen_r;
    dstart_nxt    = dstart_r;
    dlen_nxt      = dlen_r;

    if (in_xfer) begin
      pos_nxt = pos_inc;
      unique case (phase_r)
        // twelve-byte riff header, position is below twelve here
        PH_RIFF: begin
          shift_nxt = shifted;
          if (pos_r[3:2] == 2'b01) begin
            decl_nxt[{pos_r[1:0], 3'b000} +: 8] = b;
          end
          if (pos_r[3:0] == 4'd3 && shifted != rwhp_pkg::TAG_RIFF) begin
            failed_nxt = 1'b1;
          end
          if (pos_r[3:0] == 4'd11) begin
            decl_nxt    = decl_sum;
            room_nxt    = decl_sum[31:0] -
                          32'(rwhp_pkg::RIFF_HDR_BYTES + rwhp_pkg::CHUNK_HDR_BYTES);
            hdr_cnt_nxt = '0;
            if (failed_r || shifted != rwhp_pkg::TAG_WAVE || decl_sum[32] ||
                decl_sum < 33'(rwhp_pkg::RIFF_HDR_BYTES)) begin
              failed_nxt = 1'b1;
              phase_nxt  = PH_DONE;
            end else if (decl_sum >=
                         33'(rwhp_pkg::RIFF_HDR_BYTES + rwhp_pkg::CHUNK_HDR_BYTES)) begin
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end

        // eight-byte chunk header: tag then little-endian length
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (!hdr_cnt_r[2]) begin
            shift_nxt = shifted;
          end else if (hdr_cnt_r != 3'd7) begin
            len_lo_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = b;
          end
          if (hdr_cnt_r == 3'd7) begin
            priority if (diff[32]) begin
              failed_nxt = 1'b1;
            end else if (shift_r == rwhp_pkg::TAG_FMT) begin
              if (fmt_seen_r || len_full < 32'(rwhp_pkg::FMT_BASE_BYTES)) begin
                failed_nxt = 1'b1;
              end else begin
                fmt_seen_nxt = 1'b1;
                if (len_full > 32'(rwhp_pkg::FMT_BASE_BYTES)) begin
                  xstart_nxt = pos_r[31:0] + 32'(rwhp_pkg::FMT_BASE_BYTES + 1);
                  xlen_nxt   = len_full - 32'(rwhp_pkg::FMT_BASE_BYTES);
                end
              end
            end else if (shift_r == rwhp_pkg::TAG_DATA) begin
              if (data_seen_r) begin
                failed_nxt = 1'b1;
              end else begin
                data_seen_nxt = 1'b1;
                dstart_nxt    = pos_inc[31:0];
                dlen_nxt      = len_full;
              end
            end else begin
              // unknown chunk, skipped
            end

            if (failed_nxt) begin
              phase_nxt = PH_DONE;
            end else if (len_full == '0) begin
              if (room_r >= 32'(rwhp_pkg::CHUNK_HDR_BYTES)) begin
                room_nxt  = room_r - 32'(rwhp_pkg::CHUNK_HDR_BYTES);
                phase_nxt = PH_HEADER;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt     = PH_BODY;
              room_nxt      = diff[31:0];
              pad_nxt       = len_full[0];
              body_left_nxt = len_full[0] ? len_full : len_full - 32'd1;
              body_idx_nxt  = '0;
              fmt_body_nxt  = (shift_r == rwhp_pkg::TAG_FMT);
            end
          end
        end

        // chunk payload plus pad byte
        PH_BODY: begin
          if (fmt_body_r && !body_idx_r[4]) begin
            unique case (body_idx_r[3:0])
              4'd0, 4'd1: format_nxt[{body_idx_r[0], 3'b000} +: 8] = b;
              4'd2, 4'd3: chan_nxt[{body_idx_r[0], 3'b000} +: 8] = b;
              4'd4, 4'd5, 4'd6, 4'd7:
                rate_nxt[{body_idx_r[1:0], 3'b000} +: 8] = b;
              4'd8, 4'd9, 4'd10, 4'd11:
                brate_nxt[{body_idx_r[1:0], 3'b000} +: 8] = b;
              4'd12, 4'd13: align_nxt[{body_idx_r[0], 3'b000} +: 8] = b;
              default: bits_nxt[{body_idx_r[0], 3'b000} +: 8] = b;
            endcase
          end
          if (!body_idx_r[4]) begin
            body_idx_nxt = body_idx_r + 5'd1;
          end
          body_left_nxt = body_left_r - 32'd1;
          if (body_left_r == '0) begin
            if (room_r >= room_need) begin
              room_nxt    = room_r - room_need;
              hdr_cnt_nxt = '0;
              phase_nxt   = PH_HEADER;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end

        // past the declared end or failed: bytes only counted
        PH_DONE: begin
        end

        default: begin
        end
      endcase
    end
  end

  // verdict on the state that includes the current byte
  assign res_ok = !failed_nxt &&
                  pos_nxt >= 33'(rwhp_pkg::RIFF_HDR_BYTES) && !pos_nxt[32] &&
                  decl_nxt <= pos_nxt && fmt_seen_nxt && data_seen_nxt &&
                  format_nxt == rwhp_pkg::FMT_PCM && chan_nxt != '0 &&
                  rate_nxt != '0 && brate_nxt != '0 && align_nxt != '0 &&
                  bits_nxt != '0 && dlen_nxt != '0;

  always_comb begin
    out_data_nxt = '0;
    if (res_ok) begin
      out_data_nxt.valid_res    = 1'b1;
      out_data_nxt.channels     = chan_nxt;
      out_data_nxt.sample_rate  = rate_nxt;
      out_data_nxt.byte_rate    = brate_nxt;
      out_data_nxt.frame_bytes  = align_nxt;
      out_data_nxt.sample_width = bits_nxt;
      out_data_nxt.extra_offset = xstart_nxt;
      out_data_nxt.extra_length = xlen_nxt;
      out_data_nxt.data_offset  = dstart_nxt;
      out_data_nxt.data_length  = dlen_nxt;
      out_data_nxt.riff_length  = decl_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    // a resource ends at its last byte, so the parser starts over
    if (!rst_n || (in_xfer && in_data.last)) begin
      phase_r     <= PH_RIFF;
      pos_r       <= '0;
      decl_r      <= '0;
      room_r      <= '0;
      shift_r     <= '0;
      len_lo_r    <= '0;
      hdr_cnt_r   <= '0;
      body_left_r <= '0;
      body_idx_r  <= '0;
      pad_r       <= 1'b0;
      fmt_body_r  <= 1'b0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      failed_r    <= 1'b0;
      format_r    <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      brate_r     <= '0;
      align_r     <= '0;
      bits_r      <= '0;
      xstart_r    <= '0;
      xlen_r      <= '0;
      dstart_r    <= '0;
      dlen_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      decl_r      <= decl_nxt;
      room_r      <= room_nxt;
      shift_r     <= shift_nxt;
      len_lo_r    <= len_lo_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      body_left_r <= body_left_nxt;
      body_idx_r  <= body_idx_nxt;
      pad_r       <= pad_nxt;
      fmt_body_r  <= fmt_body_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      failed_r    <= failed_nxt;
      format_r    <= format_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      brate_r     <= brate_nxt;
      align_r     <= align_nxt;
      bits_r      <= bits_nxt;
      xstart_r    <= xstart_nxt;
      xlen_r      <= xlen_nxt;
      dstart_r    <= dstart_nxt;
      dlen_r      <= dlen_nxt;
    end

    // output register: loaded by a last byte, freed by a result transfer
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end

    if (in_xfer && in_data.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/rwhp_checker.sv */
// ----------------------------------------------------------------------------
// rwhp_checker
// port-level checks on the riff wave header parser, bound into each parser instance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "riff_wave_header_parser_macros.svh"

module rwhp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input rwhp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input rwhp_pkg::out_t out_data
);

  // a stalled result holds
  `RWHP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // a new result only follows the transfer of a last byte
  `RWHP_ASSERT(a_out_cause, $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last), "result without last byte")

  // a rejected resource reports all fields zero
  `RWHP_ASSERT(a_invalid_zero, out_valid && !out_data.valid_res |-> out_data == '0, "invalid result carries data")

  // an accepted resource has a sane size and payload
  `RWHP_ASSERT(a_valid_sane, out_valid && out_data.valid_res |-> out_data.riff_length >= 32'(rwhp_pkg::RIFF_HDR_BYTES) && out_data.data_length != '0 && out_data.channels != '0, "valid result out of range")

  // reset empties the output
  `RWHP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (.*);
